### rtl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants of the matrix multiply core
// Sizes of the element stores and of the accumulator chain, item kind codes,
// register indexes and the product token that walks along the cell chain.
// ----------------------------------------------------------------------------
package mmc_pkg;

    // Largest matrix dimension the stores can hold.
    localparam int MAX_DIM   = 16;
    // Largest dimension a register can select (the index fields are 4 bits).
    localparam int DIM_LIMIT = (MAX_DIM < 16) ? MAX_DIM : 16;

    // Store index width per dimension and the resulting address width.
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    // One accumulator cell per product column.
    localparam int NCELL  = DIM_LIMIT;
    localparam int COL_W  = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;

    // Field widths fixed by the beat format.
    localparam int CFG_W   = 5;
    localparam int CIDX_W  = 2;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 36;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Register indexes.
    localparam logic [CIDX_W-1:0] REG_A_ROWS     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_B_COLS     = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    // One product term on its way to the cell of its column.
    typedef struct packed {
        logic                     valid;
        logic                     fin;
        logic [COL_W-1:0]         col;
        logic signed [PROD_W-1:0] product;
    } mmc_token_t;

    // Zero acts as one, anything above the limit acts as the limit.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > DIM_LIMIT) begin
            r = CFG_W'(DIM_LIMIT);
        end
        return r;
    endfunction

endpackage

### rtl/matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_core: signed Q8.8 matrix product, one product row per item
// Loads elements of A and B into two on-chip stores and, on a compute beat,
// streams out one row of A*B as exact Q20.16 sums, last column marked.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | tuser: kind; tdata: row, col, element
//  m_      | out       | tdata: out_row, out_col, product; tlast: last column
//  cfg_    | in        | cfg_index: register, cfg_data: 5-bit value
//
// A compute beat keeps the input closed until its row is done: the single
// read port of each store and the one multiplier issue one term per cycle,
// the term then walks the chain of NCELL accumulator cells, and the nc sums
// leave through the output register one beat per cycle while m_tready is high.
// Reset clears the control state and sets all three dimensions to 16; the
// stores are not cleared and hold garbage until written.
// A stalled m_ side holds the core in its output phase; the next input beat
// is taken as soon as the last result sits in the output register.
//
module matrix_multiply_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Input beats.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] row_index, [7:4] col_index, [23:8] element_value
    input  logic [mmc_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [mmc_pkg::KIND_W-1:0]      s_tuser,

    // Result beats.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] out_row, [7:4] out_col, [43:8] product_value, [47:44] zero
    output logic [mmc_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,

    // Register writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mmc_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [mmc_pkg::CFG_W-1:0]       cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int COL_W  = mmc_pkg::COL_W;
    localparam int CFG_W  = mmc_pkg::CFG_W;
    localparam int IDX_W  = mmc_pkg::IDX_W;
    localparam int ADDR_W = mmc_pkg::ADDR_W;
    localparam int NCELL  = mmc_pkg::NCELL;
    localparam int POS_W  = mmc_pkg::POS_W;
    localparam int ELEM_W = mmc_pkg::ELEM_W;
    localparam int PROD_W = mmc_pkg::PROD_W;
    localparam int ACC_W  = mmc_pkg::ACC_W;

    // ------------------------------------------------------------------
    // Input beat fields and configuration registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  s_row;
    logic [POS_W-1:0]  s_col;
    logic [ELEM_W-1:0] s_elem;
    logic              s_accept;

    assign s_row    = s_tdata[3:0];
    assign s_col    = s_tdata[7:4];
    assign s_elem   = s_tdata[23:8];
    assign s_accept = s_tvalid && s_tready;

    logic [CFG_W-1:0] a_rows_reg;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] b_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg <= mmc_pkg::DIM_RESET;
            inner_reg  <= mmc_pkg::DIM_RESET;
            b_cols_reg <= mmc_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mmc_pkg::REG_A_ROWS:     a_rows_reg <= cfg_data;
                mmc_pkg::REG_INNER_SIZE: inner_reg  <= cfg_data;
                mmc_pkg::REG_B_COLS:     b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimensions after clamping.
    logic [CFG_W-1:0] nr;
    logic [CFG_W-1:0] nk;
    logic [CFG_W-1:0] nc;

    assign nr = mmc_pkg::clamp_dim(a_rows_reg);
    assign nk = mmc_pkg::clamp_dim(inner_reg);
    assign nc = mmc_pkg::clamp_dim(b_cols_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [1:0]       state_reg,  state_next;
    logic [POS_W-1:0] row_reg,    row_next;
    logic [COL_W-1:0] k_reg,      k_next;
    logic [COL_W-1:0] c_reg,      c_next;
    logic [COL_W-1:0] oc_reg,     oc_next;
    logic             start;
    logic             issue;
    logic             issue_fin;
    logic             out_load;
    logic             out_last;
    logic             chain_done;

    mmc_pkg::mmc_token_t chain_tok [NCELL+1];

    assign s_tready   = (state_reg == ST_IDLE);
    assign start      = s_accept && (s_tuser == mmc_pkg::KIND_COMPUTE) &&
                        (CFG_W'(s_row) < nr);
    assign issue      = (state_reg == ST_RUN);
    assign issue_fin  = (CFG_W'(k_reg) == nk - CFG_W'(1)) &&
                        (CFG_W'(c_reg) == nc - CFG_W'(1));
    assign chain_done = chain_tok[NCELL].valid && chain_tok[NCELL].fin;
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid || m_tready);
    assign out_last   = (CFG_W'(oc_reg) == nc - CFG_W'(1));

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        oc_next    = oc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    row_next   = s_row;
                    k_next     = '0;
                    c_next     = '0;
                end
            end
            ST_RUN: begin
                // Columns run fastest so each cell sees its terms in rising k.
                if (CFG_W'(c_reg) == nc - CFG_W'(1)) begin
                    c_next = '0;
                    k_next = k_reg + COL_W'(1);
                end else begin
                    c_next = c_reg + COL_W'(1);
                end
                if (issue_fin) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // The final term has left the chain once every cell has summed.
                if (chain_done) begin
                    state_next = ST_OUT;
                    oc_next    = '0;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    if (out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        oc_next = oc_reg + COL_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        row_reg <= row_next;
        k_reg   <= k_next;
        c_reg   <= c_next;
        oc_reg  <= oc_next;
    end

    // ------------------------------------------------------------------
    // Element stores: one write and one registered read per cycle each
    // ------------------------------------------------------------------
    logic [ELEM_W-1:0] mem_a [2**ADDR_W];
    logic [ELEM_W-1:0] mem_b [2**ADDR_W];
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_ok;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;

    assign wr_addr   = {IDX_W'(s_row), IDX_W'(s_col)};
    assign wr_ok     = (int'(s_row) < mmc_pkg::MAX_DIM) && (int'(s_col) < mmc_pkg::MAX_DIM);
    assign rd_addr_a = {IDX_W'(row_reg), IDX_W'(k_reg)};
    assign rd_addr_b = {IDX_W'(k_reg), IDX_W'(c_reg)};

    always_ff @(posedge aclk) begin
        if (s_accept && wr_ok && (s_tuser == mmc_pkg::KIND_WRITE_A)) begin
            mem_a[wr_addr] <= s_elem;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && wr_ok && (s_tuser == mmc_pkg::KIND_WRITE_B)) begin
            mem_b[wr_addr] <= s_elem;
        end
    end

    logic [ELEM_W-1:0] a_q_reg;
    logic [ELEM_W-1:0] b_q_reg;
    logic              rd_vld_reg;
    logic              rd_fin_reg;
    logic [COL_W-1:0]  rd_col_reg;

    always_ff @(posedge aclk) begin
        a_q_reg <= mem_a[rd_addr_a];
        b_q_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
        end
        rd_fin_reg <= issue_fin;
        rd_col_reg <= c_reg;
    end

    // ------------------------------------------------------------------
    // Multiplier stage feeding the head of the chain
    // ------------------------------------------------------------------
    mmc_pkg::mmc_token_t mul_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg.valid <= 1'b0;
        end else begin
            mul_reg.valid <= rd_vld_reg;
        end
        mul_reg.fin     <= rd_fin_reg;
        mul_reg.col     <= rd_col_reg;
        mul_reg.product <= PROD_W'($signed(a_q_reg)) * PROD_W'($signed(b_q_reg));
    end

    // ------------------------------------------------------------------
    // Chain of accumulator cells, one per product column
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc [NCELL];

    assign chain_tok[0] = mul_reg;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        mmc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (start),
            .idx     (COL_W'(i)),
            .tok_in  (chain_tok[i]),
            .tok_out (chain_tok[i+1]),
            .acc     (acc[i])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                    m_valid_reg;
    logic [POS_W-1:0]        m_row_reg;
    logic [POS_W-1:0]        m_col_reg;
    logic signed [ACC_W-1:0] m_sum_reg;
    logic                    m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_row_reg  <= row_reg;
            m_col_reg  <= POS_W'(oc_reg);
            m_sum_reg  <= acc[oc_reg];
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0000, m_sum_reg, m_col_reg, m_row_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_only_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_done |-> (state_reg == ST_WAIT))
        else $error("final term left the chain outside the wait phase");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !mul_reg.valid))
        else $error("terms still in flight while idle");

    a_result_from_out_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result appeared outside the output phase");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CFG_W'(m_col_reg) < nc))
        else $error("result column beyond the configured column count");

endmodule

### rtl/mmc_cell.sv
// ----------------------------------------------------------------------------
// mmc_cell: one accumulator cell of the product chain
// Passes the incoming token on to its neighbor every cycle, adds its product
// to the sum when the token is for its column, and zeroes the sum on clear.
// ----------------------------------------------------------------------------
module mmc_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            clear,
    input  logic [mmc_pkg::COL_W-1:0]       idx,
    input  mmc_pkg::mmc_token_t             tok_in,
    output mmc_pkg::mmc_token_t             tok_out,
    output logic signed [mmc_pkg::ACC_W-1:0] acc
);

    mmc_pkg::mmc_token_t              tok_reg;
    logic signed [mmc_pkg::ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_in.valid;
        end
        tok_reg.fin     <= tok_in.fin;
        tok_reg.col     <= tok_in.col;
        tok_reg.product <= tok_in.product;
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            acc_reg <= '0;
        end else if (tok_in.valid && (tok_in.col == idx)) begin
            acc_reg <= acc_reg + mmc_pkg::ACC_W'(tok_in.product);
        end
    end

    assign tok_out = tok_reg;
    assign acc     = acc_reg;

endmodule

### tb/matrix_multiply_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_core_tb: self-checking bench for the matrix multiply core
// Loads elements of A and B, requests product rows under several dimension
// settings and checks every result beat against a behavioral product model.
// ----------------------------------------------------------------------------
module matrix_multiply_core_tb;

    import mmc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 5;
    // Quiet cycles at the end of each phase; they guarantee that a row with no
    // output has finished as well.
    localparam int DRAIN_CYCLES = 320;
    // Length of the one long stall on the result side.
    localparam int HOLD_CYCLES  = 500;

    // The fourth kind code has no function in the core.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One input beat as the sender sees it.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } matrix_beat_t;

    // One expected product element.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [ACC_W-1:0] value;
        logic             last;
    } product_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    matrix_multiply_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shared state between stimulus, driver and monitor.
    // ------------------------------------------------------------------------
    matrix_beat_t  queued_beats[$];       // beats still to be offered
    product_beat_t expected_products[$];  // product elements still to arrive

    int s_beats_offered = 0;   // written by the driver only
    int s_beats_taken   = 0;   // written by the monitor only
    int results_seen    = 0;
    int error_count     = 0;

    // Steady flow turns off the random gaps on both sides for a whole phase.
    bit   steady_flow = 1'b0;
    logic hold_off    = 1'b0;

    // Behavioral copy of the core: both element stores and the raw register
    // values, updated on accepted beats only.
    logic [ELEM_W-1:0] model_a [0:DEPTH-1];
    logic [ELEM_W-1:0] model_b [0:DEPTH-1];
    logic [CFG_W-1:0]  model_rows  = DIM_RESET;
    logic [CFG_W-1:0]  model_inner = DIM_RESET;
    logic [CFG_W-1:0]  model_cols  = DIM_RESET;

    // Stimulus side bookkeeping: which store entries have been loaded, so that
    // a product row is never requested over entries that hold garbage.
    bit a_loaded [0:DEPTH-1];
    bit b_loaded [0:DEPTH-1];
    int gen_rows  = DIM_LIMIT;
    int gen_inner = DIM_LIMIT;
    int gen_cols  = DIM_LIMIT;
    int budget_used;

    // A zero register acts as one, anything past the limit acts as the limit.
    function automatic int effective_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > DIM_LIMIT) begin
            return DIM_LIMIT;
        end
        return int'(raw);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return 0;
        end else if (sel < 85) begin
            return $urandom_range(1, 3);
        end else if (sel < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Element values lean toward the extremes so that the large sums occur.
    function automatic logic [ELEM_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1: begin
                return 16'h8000;
            end
            2, 3: begin
                return 16'h7FFF;
            end
            4: begin
                return 16'h0000;
            end
            5: begin
                return 16'hFFFF;
            end
            default: begin
                return ELEM_W'($urandom());
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Product model. Writes land in the store copy; a compute beat on a row
    // that exists yields one element per product column, summed in increasing
    // k with full precision and wrapped to the 36-bit output field.
    // ------------------------------------------------------------------------
    task automatic apply_matrix_beat(input logic [KIND_W-1:0] kind,
                                     input logic [POS_W-1:0] row,
                                     input logic [POS_W-1:0] col,
                                     input logic [ELEM_W-1:0] value);
        int                       nr;
        int                       nk;
        int                       nc;
        longint                   acc;
        logic signed [ELEM_W-1:0] ea;
        logic signed [ELEM_W-1:0] eb;
        product_beat_t            prod;
        nr = effective_dim(model_rows);
        nk = effective_dim(model_inner);
        nc = effective_dim(model_cols);
        if (kind == KIND_WRITE_A) begin
            model_a[int'(row) * MAX_DIM + int'(col)] = value;
        end else if (kind == KIND_WRITE_B) begin
            model_b[int'(row) * MAX_DIM + int'(col)] = value;
        end else if (kind == KIND_COMPUTE && int'(row) < nr) begin
            for (int c = 0; c < nc; c++) begin
                acc = 0;
                for (int k = 0; k < nk; k++) begin
                    ea  = model_a[int'(row) * MAX_DIM + k];
                    eb  = model_b[k * MAX_DIM + c];
                    acc = acc + longint'(ea) * longint'(eb);
                end
                prod.row   = row;
                prod.col   = POS_W'(c);
                prod.value = ACC_W'(acc);
                prod.last  = (c == nc - 1);
                expected_products.push_back(prod);
            end
        end
    endtask

    task automatic apply_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        case (idx)
            REG_A_ROWS: begin
                model_rows = value;
            end
            REG_INNER_SIZE: begin
                model_inner = value;
            end
            REG_B_COLS: begin
                model_cols = value;
            end
            default: begin
            end
        endcase
    endtask

    // Compares one result beat with the oldest expected element.
    task automatic check_product_beat();
        product_beat_t want;
        logic [POS_W-1:0] got_row;
        logic [POS_W-1:0] got_col;
        logic [ACC_W-1:0] got_value;
        got_row   = m_tdata[3:0];
        got_col   = m_tdata[7:4];
        got_value = m_tdata[43:8];
        results_seen++;
        if (expected_products.size() == 0) begin
            $error("unexpected result beat: row %0d col %0d value %0d",
                   got_row, got_col, $signed(got_value));
            error_count++;
        end else begin
            want = expected_products.pop_front();
            if (got_row !== want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, got_row);
                error_count++;
            end
            if (got_col !== want.col) begin
                $error("out_col: expected %0d, actual %0d", want.col, got_col);
                error_count++;
            end
            if (got_value !== want.value) begin
                $error("product_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(got_value));
                error_count++;
            end
            if (m_tlast !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, m_tlast);
                error_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the inputs have
    // been stable since the falling edge before it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                apply_matrix_beat(s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[23:8]);
                s_beats_taken++;
            end
            if (m_tvalid && m_tready) begin
                check_product_beat();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input driver. A beat stays on the bus until the monitor has seen it
    // taken; then, after its gap, the next queued beat follows. A beat that
    // follows without a gap keeps s_tvalid high through the change of data.
    // ------------------------------------------------------------------------
    int s_gap = 0;

    always @(negedge aclk) begin
        matrix_beat_t next_beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && s_beats_taken != s_beats_offered)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (queued_beats.size() != 0) begin
                next_beat = queued_beats.pop_front();
                s_tdata  <= {next_beat.value, next_beat.col, next_beat.row};
                s_tuser  <= next_beat.kind;
                s_tvalid <= 1'b1;
                s_beats_offered++;
                s_gap = steady_flow ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Random stalls of random length, and on top of them the
    // long hold-off from the pressure process below.
    // ------------------------------------------------------------------------
    int m_stall = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off;
            if (!steady_flow && $urandom_range(0, 4) == 0) begin
                m_stall = pick_gap();
            end
        end
    end

    // Once the run is well under way and a good number of beats is still
    // queued, the receiver stops for a long stretch while the sender keeps
    // offering beats. The core fills up, sits in its output phase and has to
    // hold off its input.
    initial begin
        while (results_seen < 20 || queued_beats.size() < 8) begin
            @(negedge aclk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. They only fill the queue; the driver paces it.
    // ------------------------------------------------------------------------
    task automatic queue_element(input logic [KIND_W-1:0] kind, input int row,
                                 input int col, input logic [ELEM_W-1:0] value);
        matrix_beat_t b;
        b.kind  = kind;
        b.row   = POS_W'(row);
        b.col   = POS_W'(col);
        b.value = value;
        queued_beats.push_back(b);
        if (kind == KIND_WRITE_A) begin
            a_loaded[row * MAX_DIM + col] = 1'b1;
        end else begin
            b_loaded[row * MAX_DIM + col] = 1'b1;
        end
        budget_used++;
    endtask

    // Beat of the unused kind, all fields random. It must change nothing.
    task automatic queue_noise();
        matrix_beat_t b;
        b.kind  = KIND_UNUSED;
        b.row   = POS_W'($urandom());
        b.col   = POS_W'($urandom());
        b.value = ELEM_W'($urandom());
        queued_beats.push_back(b);
    endtask

    // Requests a product row. For a row that exists, any store entry that the
    // row reads and that was never loaded gets loaded first. The column and
    // element fields of a compute beat are don't-care and carry random bits.
    task automatic queue_compute(input int row);
        matrix_beat_t b;
        if (row < gen_rows) begin
            for (int k = 0; k < gen_inner; k++) begin
                if (!a_loaded[row * MAX_DIM + k]) begin
                    queue_element(KIND_WRITE_A, row, k, pick_value());
                end
            end
            for (int k = 0; k < gen_inner; k++) begin
                for (int c = 0; c < gen_cols; c++) begin
                    if (!b_loaded[k * MAX_DIM + c]) begin
                        queue_element(KIND_WRITE_B, k, c, pick_value());
                    end
                end
            end
            budget_used++;
        end
        b.kind  = KIND_COMPUTE;
        b.row   = POS_W'(row);
        b.col   = POS_W'($urandom());
        b.value = ELEM_W'($urandom());
        queued_beats.push_back(b);
    endtask

    // Waits until every beat is taken and every product element has arrived,
    // then lets the core finish any row that produces no output.
    task automatic wait_idle();
        while (queued_beats.size() != 0 || s_tvalid || expected_products.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write; cfg_valid stays high for a write that follows.
    task automatic write_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // Writes all three dimensions. Only called with the core idle.
    task automatic set_dimensions(input int raw_rows, input int raw_inner,
                                  input int raw_cols);
        write_register(REG_A_ROWS, CFG_W'(raw_rows));
        write_register(REG_INNER_SIZE, CFG_W'(raw_inner));
        write_register(REG_B_COLS, CFG_W'(raw_cols));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_rows  = effective_dim(CFG_W'(raw_rows));
        gen_inner = effective_dim(CFG_W'(raw_inner));
        gen_cols  = effective_dim(CFG_W'(raw_cols));
    endtask

    // Random traffic for one setting. Most of it is a few loads into one row
    // of A and the B entries it meets, followed by a request for that row;
    // the rest is stray loads, requests for any row, and unused-kind beats.
    // Beats the core ignores do not count toward the budget.
    task automatic random_phase(input int budget);
        int pick;
        int row;
        budget_used = 0;
        while (budget_used < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                row = $urandom_range(0, gen_rows - 1);
                repeat ($urandom_range(1, gen_inner)) begin
                    queue_element(KIND_WRITE_A, row, $urandom_range(0, gen_inner - 1),
                                  pick_value());
                end
                repeat ($urandom_range(0, 3)) begin
                    queue_element(KIND_WRITE_B, $urandom_range(0, gen_inner - 1),
                                  $urandom_range(0, gen_cols - 1), pick_value());
                end
                queue_compute(row);
            end else if (pick < 70) begin
                queue_compute($urandom_range(0, 15));
            end else if (pick < 88) begin
                queue_element($urandom_range(0, 1) ? KIND_WRITE_B : KIND_WRITE_A,
                              $urandom_range(0, 15), $urandom_range(0, 15), pick_value());
            end else begin
                queue_noise();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part. A zero row count acts as one row; four terms and two
        // columns keep the loads few. Column 0 sums the most negative element
        // squared (largest positive sum here), column 1 the largest negative
        // products.
        set_dimensions(0, 4, 2);
        for (int k = 0; k < 4; k++) begin
            queue_element(KIND_WRITE_A, 0, k, 16'h8000);
            queue_element(KIND_WRITE_B, k, 0, 16'h8000);
            queue_element(KIND_WRITE_B, k, 1, 16'h7FFF);
        end
        queue_compute(0);
        // Loads outside the configured size stay in the store.
        queue_element(KIND_WRITE_A, 15, 15, 16'h7FFF);
        queue_element(KIND_WRITE_B, 15, 15, 16'hFFFF);
        // Unused kind and a row past the configured count: no output.
        queue_noise();
        queue_compute(15);
        // Overwrite two entries and ask again.
        queue_element(KIND_WRITE_A, 0, 2, 16'h0000);
        queue_element(KIND_WRITE_A, 0, 1, 16'h7FFF);
        queue_compute(0);
        wait_idle();

        // Smallest product.
        set_dimensions(1, 1, 1);
        random_phase(20);
        wait_idle();

        set_dimensions(4, 3, 5);
        random_phase(25);
        wait_idle();

        // Out-of-range counts act as the limit. Run without gaps.
        steady_flow = 1'b1;
        set_dimensions(31, 2, 31);
        random_phase(30);
        wait_idle();
        steady_flow = 1'b0;

        // Full row count and inner size over three columns. The first request
        // loads the B entries, later ones mostly a row of A.
        set_dimensions(16, 16, 3);
        random_phase(85);
        wait_idle();

        set_dimensions($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6));
        random_phase(20);
        wait_idle();

        set_dimensions($urandom_range(0, 31), $urandom_range(1, 3), $urandom_range(0, 31));
        random_phase(20);
        wait_idle();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Run limit, many times the slowest correct run.
    initial begin
        #(CLK_PERIOD * 1_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
